[hw/rtl/one_shot_timer_table_core_assert.svh]
// assertion helpers for the timer table, used by the port checker
`ifndef ONE_SHOT_TIMER_TABLE_CORE_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OSTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OSTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ostt_pkg.sv]
`timescale 1ns / 1ps

package ostt_pkg;

    localparam int SLOTS   = 10;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int SECS_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 24;

    localparam logic [TIME_W-1:0] US_PER_SECOND = 32'd1000000;
    localparam logic [ID_W-1:0]   ID_RESET      = '1;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_DONE,
        ST_TICK_DONE
    } ostt_state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic commit_add;
        logic flush_tick;
    } ostt_ctrl_t;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic out_free;
        logic fire_hit;
        logic pend_valid;
    } ostt_stat_t;

endpackage

[hw/rtl/ostt_datapath.sv]
`timescale 1ns / 1ps

module ostt_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ostt_pkg::ostt_ctrl_t         ctrl,
    output ostt_pkg::ostt_stat_t         stat,
    input  logic                         in_cmd,
    input  logic [ostt_pkg::IN_W-1:0]    in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_kind,
    output logic                         out_last,
    output logic [ostt_pkg::OUT_W-1:0]   out_data
);

    localparam int IDX_W  = ostt_pkg::IDX_W;
    localparam int TIME_W = ostt_pkg::TIME_W;
    localparam int ID_W   = ostt_pkg::ID_W;
    localparam int SECS_W = ostt_pkg::SECS_W;
    localparam int BYTE_W = ostt_pkg::BYTE_W;
    localparam int SLOTS  = ostt_pkg::SLOTS;

    // table
    logic [TIME_W-1:0]     exp_reg [SLOTS];
    logic signed [ID_W-1:0] id_reg [SLOTS];
    logic [BYTE_W-1:0]     tgt_reg [SLOTS];
    logic [BYTE_W-1:0]     act_reg [SLOTS];

    // captured item
    logic                  cmd_reg;
    logic [TIME_W-1:0]     now_reg;
    logic signed [ID_W-1:0] tid_reg;
    logic [SECS_W-1:0]     secs_reg;
    logic [BYTE_W-1:0]     itgt_reg;
    logic [BYTE_W-1:0]     iact_reg;
    logic [TIME_W-1:0]     prod_reg;

    // scan state
    logic [IDX_W-1:0]      idx_reg;
    logic                  match_found_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    // held fired slot, sent once the next one or the scan end is known
    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [BYTE_W-1:0]     pend_tgt_reg;
    logic [BYTE_W-1:0]     pend_act_reg;

    // output register
    logic                  ovalid_reg;
    logic                  okind_reg;
    logic                  olast_reg;
    logic [ostt_pkg::SLOT_W-1:0] oidx_reg;
    logic                  ofound_reg;
    logic [BYTE_W-1:0]     otgt_reg;
    logic [BYTE_W-1:0]     oact_reg;

    logic [TIME_W-1:0]     cur_exp;
    logic                  id_pos;
    logic                  match_hit;
    logic                  free_hit;
    logic                  fire_hit;
    logic                  add_found;
    logic [IDX_W-1:0]      add_idx;
    logic                  out_free;
    logic                  push_pend;

    assign cur_exp   = exp_reg[idx_reg];
    assign id_pos    = !tid_reg[ID_W-1] && (tid_reg != '0);
    assign match_hit = id_pos && (id_reg[idx_reg] == tid_reg);
    assign free_hit  = cur_exp < now_reg;
    assign fire_hit  = (cur_exp != '0) && free_hit;
    assign add_found = match_found_reg || free_found_reg;
    assign add_idx   = match_found_reg ? match_idx_reg : free_idx_reg;
    assign out_free  = !ovalid_reg || out_ready;
    assign push_pend = ctrl.step && (cmd_reg == ostt_pkg::CMD_TICK) && fire_hit
                       && pend_valid_reg;

    assign stat.is_tick    = (cmd_reg == ostt_pkg::CMD_TICK);
    assign stat.scan_last  = (idx_reg == IDX_W'(SLOTS - 1));
    assign stat.out_free   = out_free;
    assign stat.fire_hit   = fire_hit;
    assign stat.pend_valid = pend_valid_reg;

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
    assign out_data  = {3'b000, oact_reg, otgt_reg, ofound_reg, oidx_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= in_cmd;
            now_reg  <= in_data[31:0];
            tid_reg  <= in_data[47:32];
            secs_reg <= in_data[59:48];
            itgt_reg <= in_data[67:60];
            iact_reg <= in_data[75:68];
        end
        // seconds to microseconds, ready before the add commit
        prod_reg <= TIME_W'(secs_reg) * ostt_pkg::US_PER_SECOND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                exp_reg[i] <= '0;
                id_reg[i]  <= ostt_pkg::ID_RESET;
                tgt_reg[i] <= '0;
                act_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.commit_add && add_found)
            begin
                exp_reg[add_idx] <= now_reg + prod_reg;
                id_reg[add_idx]  <= tid_reg;
                tgt_reg[add_idx] <= itgt_reg;
                act_reg[add_idx] <= iact_reg;
            end
            if (ctrl.step && (cmd_reg == ostt_pkg::CMD_TICK) && fire_hit)
            begin
                exp_reg[idx_reg] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cmd_reg == ostt_pkg::CMD_ADD)
                begin
                    if (match_hit && !match_found_reg)
                    begin
                        match_found_reg <= 1'b1;
                    end
                    if (free_hit && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                else if (fire_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (ctrl.flush_tick)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            if (match_hit && !match_found_reg)
            begin
                match_idx_reg <= idx_reg;
            end
            if (free_hit && !free_found_reg)
            begin
                free_idx_reg <= idx_reg;
            end
            if ((cmd_reg == ostt_pkg::CMD_TICK) && fire_hit)
            begin
                pend_idx_reg <= idx_reg;
                pend_tgt_reg <= tgt_reg[idx_reg];
                pend_act_reg <= act_reg[idx_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (ctrl.commit_add || push_pend || (ctrl.flush_tick && pend_valid_reg))
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit_add)
        begin
            okind_reg  <= ostt_pkg::KIND_ACK;
            olast_reg  <= 1'b1;
            oidx_reg   <= add_found ? ostt_pkg::SLOT_W'(add_idx) : '0;
            ofound_reg <= add_found;
            otgt_reg   <= '0;
            oact_reg   <= '0;
        end
        else if (push_pend || (ctrl.flush_tick && pend_valid_reg))
        begin
            okind_reg  <= ostt_pkg::KIND_FIRED;
            olast_reg  <= ctrl.flush_tick;
            oidx_reg   <= ostt_pkg::SLOT_W'(pend_idx_reg);
            ofound_reg <= 1'b0;
            otgt_reg   <= pend_tgt_reg;
            oact_reg   <= pend_act_reg;
        end
    end

endmodule

[hw/rtl/ostt_controller.sv]
`timescale 1ns / 1ps

module ostt_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ostt_pkg::ostt_stat_t  stat,
    output ostt_pkg::ostt_ctrl_t  ctrl
);

    ostt_pkg::ostt_state_t state_reg;
    ostt_pkg::ostt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ostt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ostt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ostt_pkg::ST_SCAN;
                end
            end
            ostt_pkg::ST_SCAN:
            begin
                // a second fired slot needs the output register for the held one
                ctrl.step = !(stat.is_tick && stat.fire_hit && stat.pend_valid
                              && !stat.out_free);
                if (ctrl.step && stat.scan_last)
                begin
                    state_next = stat.is_tick ? ostt_pkg::ST_TICK_DONE
                                              : ostt_pkg::ST_ADD_DONE;
                end
            end
            ostt_pkg::ST_ADD_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.commit_add = 1'b1;
                    state_next      = ostt_pkg::ST_IDLE;
                end
            end
            ostt_pkg::ST_TICK_DONE:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    ctrl.flush_tick = 1'b1;
                    state_next      = ostt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ostt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/one_shot_timer_table_core.sv]
// Table of SLOTS one-shot timers. An add transaction (tuser = 0) arms a timer: a positive id
// already in the table reuses its slot, otherwise the first slot whose expiry is below now_us
// is taken; expiry = now_us + delay_seconds * 1000000 (mod 2^32) and one acknowledgement
// comes back with the slot or slot_found = 0. A tick transaction (tuser = 1) fires every slot
// with a nonzero expiry below now_us, in slot order, one result each with tlast on the final
// one, and clears those expiries; a tick with nothing expired returns nothing. Compares are
// plain unsigned. Items are handled one at a time by a slot scan that reads one table entry
// per cycle, except while a tick holds a second fired slot and the output register is full;
// the last result of an item is presented once the scan and its done state are through, plus
// any stalls on the result side, and the next item is accepted once the block is idle again.
// The next item is taken while the last result still waits in the output register.
`timescale 1ns / 1ps

module one_shot_timer_table_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // now_us, timer_id, delay_seconds, target_handle, action_code, zero pad
    input  logic [ostt_pkg::IN_W-1:0]    s_axis_tdata,
    // command
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // slot_index, slot_found, fired_target, fired_action, zero pad
    output logic [ostt_pkg::OUT_W-1:0]   m_axis_tdata,
    // kind
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);

    ostt_pkg::ostt_ctrl_t ctrl;
    ostt_pkg::ostt_stat_t stat;

    ostt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ostt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_cmd    (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .out_data  (m_axis_tdata)
    );

endmodule

[hw/rtl/ostt_checker.sv]
`timescale 1ns / 1ps
`include "one_shot_timer_table_core_assert.svh"

module ostt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [ostt_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                         s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [ostt_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                         m_axis_tuser,
    input  logic                         m_axis_tlast
);

    logic in_txn;
    logic unused_in;

    assign in_txn    = s_axis_tvalid && s_axis_tready;
    assign unused_in = ^{s_axis_tdata, s_axis_tuser};

    // a held result stays put until taken
    `OSTT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result dropped")

    // one item at a time: the scan follows every accepted transaction
    `OSTT_ASSERT_NXT(a_busy_after_accept, in_txn, !s_axis_tready, "accepted while busy")

    // an acknowledgement is always the only result of its item
    `OSTT_ASSERT_NOW(a_ack_last, m_axis_tvalid && (m_axis_tuser == ostt_pkg::KIND_ACK),
        m_axis_tlast && (m_axis_tdata[20:5] == '0), "malformed acknowledgement")

    // fired results never claim a slot, and a failed add reports slot zero
    `OSTT_ASSERT_NOW(a_found_rules, m_axis_tvalid && !m_axis_tdata[4],
        (m_axis_tdata[3:0] == '0) || (m_axis_tuser == ostt_pkg::KIND_FIRED),
        "slot index without slot")

    `OSTT_ASSERT_NOW(a_fired_no_found, m_axis_tvalid && (m_axis_tuser == ostt_pkg::KIND_FIRED),
        !m_axis_tdata[4] && (unused_in == unused_in), "fired result flags a slot")

endmodule

bind one_shot_timer_table_core ostt_checker u_ostt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_CMDS = 240;
    localparam int DRAIN_CYCLES = 4 * (ostt_pkg::SLOTS + 2);
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic        command;
        logic [31:0] now_us;
        logic [15:0] timer_id;
        logic [11:0] delay_seconds;
        logic [7:0]  target_handle;
        logic [7:0]  action_code;
    } timer_cmd_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] slot_index;
        logic       slot_found;
        logic [7:0] fired_target;
        logic [7:0] fired_action;
        logic       last;
    } timer_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ostt_pkg::IN_W-1:0]     s_axis_tdata = '0;
    logic                          s_axis_tuser = ostt_pkg::CMD_ADD;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ostt_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          m_axis_tlast;

    // model of the timer table
    logic [31:0] tbl_expiry [ostt_pkg::SLOTS];
    logic [15:0] tbl_owner  [ostt_pkg::SLOTS];
    logic [7:0]  tbl_target [ostt_pkg::SLOTS];
    logic [7:0]  tbl_action [ostt_pkg::SLOTS];

    timer_cmd_t   cmd_queue [$];
    timer_event_t expected_events [$];

    timer_cmd_t   drv_cmd;
    timer_event_t want;
    int           tx_gap = 0;
    logic         tx_burst = 1'b0;
    int           rx_gap = 0;
    logic         rx_burst = 1'b0;
    logic         rx_hold_on = 1'b0;
    logic         rx_hold_done = 1'b0;
    int           rx_hold_cnt = 0;

    int n_queued = 0;
    int n_sent = 0;
    int n_rcvd = 0;
    int n_adds = 0;
    int n_ticks = 0;
    int n_fired = 0;
    int n_noslot = 0;
    int err_cnt = 0;
    int cycles = 0;

    one_shot_timer_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic void clear_table();
        for (int i = 0; i < ostt_pkg::SLOTS; i++)
        begin
            tbl_expiry[i] = '0;
            tbl_owner[i]  = ostt_pkg::ID_RESET;
            tbl_target[i] = '0;
            tbl_action[i] = '0;
        end
    endfunction

    // updates the table for one accepted command and queues the events it causes
    function automatic void arm_or_fire(timer_cmd_t c);
        int           pos;
        timer_event_t ev;
        timer_event_t fired [$];
        pos = -1;
        ev = '0;
        if (c.command == ostt_pkg::CMD_ADD)
        begin
            n_adds++;
            if (!c.timer_id[15] && c.timer_id != 0)
            begin
                for (int i = 0; i < ostt_pkg::SLOTS && pos < 0; i++)
                    if (tbl_owner[i] == c.timer_id)
                        pos = i;
            end
            if (pos < 0)
            begin
                for (int i = 0; i < ostt_pkg::SLOTS && pos < 0; i++)
                    if (tbl_expiry[i] < c.now_us)
                        pos = i;
            end
            ev.kind = ostt_pkg::KIND_ACK;
            ev.last = 1'b1;
            if (pos >= 0)
            begin
                tbl_owner[pos]  = c.timer_id;
                tbl_expiry[pos] = c.now_us + 32'(c.delay_seconds) * ostt_pkg::US_PER_SECOND;
                tbl_target[pos] = c.target_handle;
                tbl_action[pos] = c.action_code;
                ev.slot_index = 4'(pos);
                ev.slot_found = 1'b1;
            end
            expected_events.push_back(ev);
        end
        else
        begin
            n_ticks++;
            for (int i = 0; i < ostt_pkg::SLOTS; i++)
            begin
                if (tbl_expiry[i] != 0 && tbl_expiry[i] < c.now_us)
                begin
                    ev.kind = ostt_pkg::KIND_FIRED;
                    ev.slot_index = 4'(i);
                    ev.slot_found = 1'b0;
                    ev.fired_target = tbl_target[i];
                    ev.fired_action = tbl_action[i];
                    ev.last = 1'b0;
                    fired.push_back(ev);
                    tbl_expiry[i] = '0;
                end
            end
            if (fired.size() > 0)
                fired[fired.size() - 1].last = 1'b1;
            foreach (fired[k])
                expected_events.push_back(fired[k]);
        end
    endfunction

    task automatic queue_cmd(logic cmd, logic [31:0] now, logic [15:0] id,
                             logic [11:0] secs, logic [7:0] tgt, logic [7:0] act);
        timer_cmd_t c;
        c.command = cmd;
        c.now_us = now;
        c.timer_id = id;
        c.delay_seconds = secs;
        c.target_handle = tgt;
        c.action_code = act;
        cmd_queue.push_back(c);
        n_queued++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= ostt_pkg::CMD_ADD;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid)
            begin
                arm_or_fire(drv_cmd);
                n_sent++;
            end
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                drv_cmd = cmd_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drv_cmd.command;
                s_axis_tdata  <= {4'b0, drv_cmd.action_code, drv_cmd.target_handle,
                                  drv_cmd.delay_seconds, drv_cmd.timer_id, drv_cmd.now_us};
                if ($urandom_range(0, 15) == 0)
                    tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 19);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // one long back-pressure stretch so the input side stalls
    always @(posedge clk)
    begin
        if (rx_hold_on)
        begin
            rx_hold_cnt++;
            if (rx_hold_cnt >= LONG_HOLD)
                rx_hold_on <= 1'b0;
        end
        else if (!rx_hold_done && n_rcvd >= 40)
        begin
            rx_hold_on   <= 1'b1;
            rx_hold_done <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_rcvd++;
                if (m_axis_tuser == ostt_pkg::KIND_FIRED)
                    n_fired++;
                else if (!m_axis_tdata[4])
                    n_noslot++;
                if (expected_events.size() == 0)
                begin
                    $error("unexpected transaction: kind %0d slot_index %0d",
                           m_axis_tuser, m_axis_tdata[3:0]);
                    err_cnt++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata[3:0] !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, m_axis_tdata[3:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[4] !== want.slot_found)
                    begin
                        $error("slot_found: expected %0d, got %0d",
                               want.slot_found, m_axis_tdata[4]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[12:5] !== want.fired_target)
                    begin
                        $error("fired_target: expected %0d, got %0d",
                               want.fired_target, m_axis_tdata[12:5]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[20:13] !== want.fired_action)
                    begin
                        $error("fired_action: expected %0d, got %0d",
                               want.fired_action, m_axis_tdata[20:13]);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_burst = ~rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (rx_hold_on)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] wall_us;
        int          sel;
        clear_table();

        // empty table at time zero: nothing counts as free
        queue_cmd(ostt_pkg::CMD_ADD, 32'd0, 16'd7, 12'd1, 8'h11, 8'h22);
        queue_cmd(ostt_pkg::CMD_TICK, 32'd0, 16'd0, 12'd0, 8'd0, 8'd0);
        // fill every slot with the same expiry
        for (int i = 0; i < ostt_pkg::SLOTS; i++)
            queue_cmd(ostt_pkg::CMD_ADD, 32'd1000, 16'(i + 1), 12'd0, 8'(8'h30 + i),
                      8'(8'hA0 + i));
        // table full, nonpositive id
        queue_cmd(ostt_pkg::CMD_ADD, 32'd1000, 16'hFFFF, 12'd2, 8'd1, 8'd2);
        // every slot fires at once
        queue_cmd(ostt_pkg::CMD_TICK, 32'd1001, 16'd0, 12'd0, 8'd0, 8'd0);
        // positive id reuses its old slot even though expiry is cleared
        queue_cmd(ostt_pkg::CMD_ADD, 32'd1001, 16'd5, 12'd4095, 8'hFF, 8'h00);
        // extremes: expiry wraps past 2^32
        queue_cmd(ostt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h7FFF, 12'd4095, 8'hFF, 8'hFF);
        queue_cmd(ostt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h8000, 12'd0, 8'h00, 8'hFF);
        queue_cmd(ostt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h7FFF, 12'd1, 8'h5A, 8'hA5);
        queue_cmd(ostt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h0000, 12'd3, 8'h0F, 8'hF0);
        queue_cmd(ostt_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'h0000, 12'd0, 8'd0, 8'd0);
        queue_cmd(ostt_pkg::CMD_TICK, 32'd5, 16'd0, 12'd0, 8'd0, 8'd0);

        wall_us = 32'd5_000_000;
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
                queue_cmd(1'($urandom), $urandom, 16'($urandom), 12'($urandom),
                          8'($urandom), 8'($urandom));
            else
            begin
                wall_us = wall_us + $urandom_range(0, 1_500_000);
                if (sel < 70)
                    queue_cmd(ostt_pkg::CMD_ADD, wall_us, 16'($urandom_range(0, 14) - 2),
                              12'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                else
                    queue_cmd(ostt_pkg::CMD_TICK, wall_us, 16'($urandom), 12'($urandom),
                              8'($urandom), 8'($urandom));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_queued || expected_events.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d adds and %0d ticks sent, %0d transactions checked", n_adds, n_ticks,
                 n_rcvd);
        $display("%0d timers fired, %0d adds found no free slot", n_fired, n_noslot);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ostt_pkg.sv
hw/rtl/ostt_datapath.sv
hw/rtl/ostt_controller.sv
hw/rtl/one_shot_timer_table_core.sv
hw/rtl/ostt_checker.sv
tb/tb.sv
